FILE: hdl/b2da_pkg.sv
// shared constants for the binary to decimal ascii converter
package b2da_pkg;

   localparam int VALUE_WIDTH = 32;

   // decimal digits needed for the largest value: floor(w * log10(2)) + 1
   localparam int DIGIT_COUNT = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;
   localparam int DIGIT_IDX_WIDTH = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   localparam logic [5:0] ASCII_ZERO = 6'd48;

endpackage

FILE: hdl/binary_to_decimal_ascii.sv
// top level: unsigned binary value in, decimal ascii digits out
// Converts one unsigned 32-bit request into its decimal text, sent as a run
// of ascii digit responses, most significant digit first, with leading
// zeros dropped; zero gives a single '0'. The final digit of each run has
// rsp_last_digit set. A request is taken while the block is idle, then the
// single shift-and-add-3 unit converts it at one input bit per cycle,
// then one digit leaves per cycle while rsp_ready is high. req_ready stays
// low from the request until its last digit is loaded into the output
// register. The last
// digit waits in the output register, so the next request is accepted
// while it is still pending.
module binary_to_decimal_ascii (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [5:0]                        rsp_digit_char,
   output logic                              rsp_last_digit
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                             state_ff, state_in;
   logic [b2da_pkg::DIGIT_IDX_WIDTH-1:0]  idx_ff, idx_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]                            rsp_char_ff, rsp_char_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic                                  req_accept;
   logic                                  conv_done;
   logic [b2da_pkg::BCD_WIDTH-1:0]        conv_bcd;
   logic [b2da_pkg::DIGIT_IDX_WIDTH-1:0]  top_idx;
   logic [3:0]                            cur_digit;
   logic                                  out_free;

   // only idle takes a new request
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;

   b2da_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .value (req_value),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   // position of the most significant nonzero digit, zero if all zero
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < b2da_pkg::DIGIT_COUNT; i++) begin
         if (conv_bcd[4*i +: 4] != 4'd0) begin
            top_idx = b2da_pkg::DIGIT_IDX_WIDTH'(i);
         end
      end
   end

   // bcd result holds steady in the unit until the next request
   assign cur_digit = conv_bcd[4*idx_ff +: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               idx_in   = top_idx;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

`ifndef ASSERT_OFF
   // emitted characters are always decimal digits
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57))
      else $error("response character outside '0'..'9'");

   // the conversion unit finishes only while the sequencer waits for it
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == ST_CONV))
      else $error("conversion finished outside conversion state");

   // first digit of a run is nonzero unless it is the only digit
   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && conv_done) |=>
         (idx_ff == '0 || cur_digit != 4'd0))
      else $error("leading zero selected");

   // leaving the emit state always leaves a last digit behind
   a_run_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=>
         (rsp_valid && rsp_last_digit))
      else $error("run ended without a last digit");
`endif

endmodule

FILE: hdl/b2da_dabble.sv
// shift-and-add-3 binary to bcd unit, one input bit per cycle
module b2da_dabble (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]  value,
   output logic                              done,
   output logic [b2da_pkg::BCD_WIDTH-1:0]    bcd
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [b2da_pkg::BIT_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [b2da_pkg::VALUE_WIDTH-1:0]    bin_ff, bin_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]      bcd_ff, bcd_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]      adjusted;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < b2da_pkg::DIGIT_COUNT; i++) begin
         adjusted[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                              bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = b2da_pkg::BIT_CNT_WIDTH'(b2da_pkg::VALUE_WIDTH);
         bin_in  = value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adjusted[b2da_pkg::BCD_WIDTH-2:0], bin_ff[b2da_pkg::VALUE_WIDTH-1]};
         bin_in = {bin_ff[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == b2da_pkg::BIT_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

FILE: bench/b2da_checker.sv
// checker for the binary to decimal ascii converter: predicts digit runs and compares them
module b2da_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [5:0]                        rsp_digit_char,
   input  logic                              rsp_last_digit,
   output int                                fail_count,
   output int                                digits_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RADIX      = 10;
   localparam int MAX_DIGITS = 20;

   typedef struct packed {
      logic [5:0] digit_char;
      logic       last_digit;
   } digit_type;

   digit_type digits_due[$];

   // decimal text of one request, most significant digit first
   task automatic queue_decimal_digits(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      logic [63:0] rest;
      logic [3:0]  rev[MAX_DIGITS];
      int          count;
      digit_type   d;
      rest = 64'(value);
      count = 0;
      if (rest == 0) begin
         rev[0] = 4'd0;
         count = 1;
      end
      while (rest != 0 && count < MAX_DIGITS) begin
         rev[count] = 4'(rest % RADIX);
         rest = rest / RADIX;
         count++;
      end
      for (int k = 0; k < count; k++) begin
         d.digit_char = b2da_pkg::ASCII_ZERO + 6'(rev[count - 1 - k]);
         d.last_digit = (k == count - 1);
         digits_due.push_back(d);
      end
   endtask

   always @(posedge clock) begin
      digit_type want;
      if (reset) begin
         digits_due.delete();
      end else begin
         // a digit can never belong to the request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (digits_due.size() == 0) begin
               $error("unexpected digit: digit_char %0d last_digit %0d",
                      rsp_digit_char, rsp_last_digit);
               fail_count++;
            end else begin
               want = digits_due.pop_front();
               if (rsp_digit_char !== want.digit_char) begin
                  $error("digit_char: expected %0d, got %0d",
                         want.digit_char, rsp_digit_char);
                  fail_count++;
               end
               if (rsp_last_digit !== want.last_digit) begin
                  $error("last_digit: expected %0d, got %0d",
                         want.last_digit, rsp_last_digit);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            queue_decimal_digits(req_value);
      end
      digits_pending = digits_due.size();
   end

endmodule

FILE: bench/testbench.sv
// top of the converter bench: clock, reset, request and response traffic, verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 250;
   // limit on the whole run: far above the worst case of idle gaps,
   // conversion and stalled digits for every request of the run
   localparam int CYCLE_LIMIT     = 200000;
   // extra cycles to wait after the last digit before the verdict
   localparam int DRAIN_CYCLES    = 60;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [b2da_pkg::VALUE_WIDTH-1:0]  req_value;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [5:0]                        rsp_digit_char;
   logic                              rsp_last_digit;

   int fail_count;
   int digits_pending;
   int cycle_count;

   // when set, neither side idles: back to back requests and no stalls
   bit no_idle;

   binary_to_decimal_ascii i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   b2da_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .fail_count     (fail_count),
      .digits_pending (digits_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // 10 to the n, wide enough for the 10 digit boundary
   function automatic logic [63:0] ten_to_the(input int n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   // random value, weighted toward every run length and the digit boundaries
   function automatic logic [b2da_pkg::VALUE_WIDTH-1:0] pick_value();
      int          kind;
      int          n;
      logic [63:0] lo;
      logic [63:0] hi;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         // full range: mostly 9 and 10 digit runs
         return b2da_pkg::VALUE_WIDTH'($urandom);
      end else if (kind <= 6) begin
         // uniform over run length, random digits within that length
         n = $urandom_range(1, 10);
         lo = (n == 1) ? 64'd0 : ten_to_the(n - 1);
         hi = ten_to_the(n) - 64'd1;
         if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
         return b2da_pkg::VALUE_WIDTH'(lo + ({32'd0, $urandom} % (hi - lo + 64'd1)));
      end else if (kind == 7) begin
         // powers of ten and the all-nines value just below them
         n = $urandom_range(0, 9);
         return b2da_pkg::VALUE_WIDTH'(ten_to_the(n) - 64'($urandom_range(0, 1)));
      end else begin
         // short runs
         return b2da_pkg::VALUE_WIDTH'($urandom_range(0, 999));
      end
   endfunction

   // one request; returns at the falling edge after the handshake with valid
   // still high, so a zero gap next time just swaps the value
   task automatic send_value(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold off new requests until every predicted digit has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      wait (digits_pending == 0);
      @(negedge clock);
   endtask

   // response side: after each digit, a random stall with rsp_ready low, none when no_idle is set
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // request side and verdict
   initial begin
      logic [b2da_pkg::VALUE_WIDTH-1:0] directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      no_idle = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero gives a lone '0'; then one and ten digit extremes, all ones,
      // alternating bit patterns and the 1/2, 2/3 and 9/10 digit boundaries
      directed = '{32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100,
                   32'd12345, 32'd999999999, 32'd1000000000, 32'd1234567890,
                   32'd2147483647, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'd4000000000, 32'd4294967294, 32'hFFFF_FFFF, 32'd0};
      foreach (directed[i])
         send_value(directed[i]);

      // let the directed runs drain completely before the random part
      wait_for_drain();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // every 25 requests, sometimes switch to a stretch with no idling
         if (i % 25 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         // one drain pause in the middle of the random traffic
         if (i == RANDOM_REQUESTS / 2)
            wait_for_drain();
         send_value(pick_value());
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      wait (digits_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
